@@ design/cpt_pkg.sv @@
// Types and constants shared by the call progress tone cadencer.
package cpt_pkg;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_PLAY = 2'd1;
   localparam logic [1:0] REQ_STOP = 2'd2;

   localparam logic [3:0] KIND_OFF      = 4'd0;
   localparam logic [3:0] KIND_T600     = 4'd1;
   localparam logic [3:0] KIND_T1000    = 4'd2;
   localparam logic [3:0] KIND_T2100    = 4'd3;
   localparam logic [3:0] KIND_STATION  = 4'd4;
   localparam logic [3:0] KIND_CALL     = 4'd5;
   localparam logic [3:0] KIND_SENDCTRL = 4'd6;
   localparam logic [3:0] KIND_BUSY     = 4'd7;
   localparam logic [3:0] KIND_UNAVAIL  = 4'd8;
   localparam logic [3:0] KIND_OPVACK   = 4'd9;
   localparam logic [3:0] KIND_WAVE1    = 4'd10;
   localparam logic [3:0] KIND_WAVE3    = 4'd12;

   localparam logic [2:0] TONE_NONE = 3'd0;
   localparam logic [2:0] TONE_600  = 3'd1;
   localparam logic [2:0] TONE_1000 = 3'd2;
   localparam logic [2:0] TONE_2100 = 3'd3;
   localparam logic [2:0] TONE_425  = 3'd4;
   localparam logic [2:0] TONE_1200 = 3'd5;
   localparam logic [2:0] TONE_WAVE = 3'd6;

   localparam logic [31:0] CALL_BEEP_MS    = 32'd100;
   localparam logic [31:0] CALL_PAUSE_MS   = 32'd3000;
   localparam logic [31:0] SEND_ON_MS      = 32'd1000;
   localparam logic [31:0] SEND_OFF_MS     = 32'd4000;
   localparam logic [31:0] BUSY_SEG_MS     = 32'd300;
   localparam logic [15:0] BUSY_BURST_MS   = 16'd600;
   localparam logic [31:0] UNAVAIL_STEP_MS = 32'd330;
   localparam logic [31:0] OPV_ON_MS       = 32'd200;
   localparam logic [31:0] OPV_OFF_MS      = 32'd5000;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  signal_kind;
      logic [15:0] length_ms;
   } cpt_req_type;

   typedef struct packed {
      logic       active;
      logic [3:0] current_kind;
      logic       muted;
      logic [2:0] tone_select;
      logic       attenuated;
   } cpt_rsp_type;

   typedef struct packed {
      logic       atten;
      logic [2:0] tone;
      logic       mute;
   } cpt_flags_type;

   typedef struct packed {
      logic [2:0]    phase;
      logic [31:0]   start;
      logic [15:0]   length;
      cpt_flags_type flags;
   } cpt_sig_type;

   typedef struct packed {
      logic [31:0] now;
      logic [3:0]  cur_kind;
      cpt_sig_type cur;
      logic [3:0]  saved_kind;
      cpt_sig_type saved;
   } cpt_state_type;

endpackage

@@ design/call_progress_tone_cadencer.sv @@
// Top level of the call progress tone cadencer: input register, state and result register.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | cpt_req_type (tick, play, stop)
//   rsp     | out       | rsp_valid/rsp_ready  | cpt_rsp_type (one per request word)
//
// One request word is taken per cycle while the result side is not stalled.
// The signal state updates in the cycle a word moves from the input register to the
// result register, through one pass of the cadence logic.
// Reset clears the millisecond count, both signals and all valid flags.
// A stalled result holds the result register; the input register still fills behind it.
module call_progress_tone_cadencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cpt_pkg::cpt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cpt_pkg::cpt_rsp_type rsp_data
);
   import cpt_pkg::*;

   logic          in_valid_ff, in_valid_in;
   cpt_req_type   in_word_ff;
   cpt_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   cpt_rsp_type   out_word_ff, out_word_in;
   logic          advance;

   cpt_engine u_engine (
      .state      (state_ff),
      .req        (in_word_ff),
      .next_state (state_in),
      .rsp        (out_word_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_valid || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_word_ff <= req_data;
      if (advance) out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

@@ design/cpt_engine.sv @@
// Next-state and report logic for one word of the cadencer.
module cpt_engine (
   input  cpt_pkg::cpt_state_type state,
   input  cpt_pkg::cpt_req_type   req,
   output cpt_pkg::cpt_state_type next_state,
   output cpt_pkg::cpt_rsp_type   rsp
);
   import cpt_pkg::*;

   function automatic cpt_state_type end_signal(input cpt_state_type s);
      cpt_state_type r;
      r = s;
      if (s.saved_kind != KIND_OFF) begin
         r.cur_kind   = s.saved_kind;
         r.cur        = s.saved;
         r.saved_kind = KIND_OFF;
      end else begin
         r.cur_kind     = KIND_OFF;
         r.cur.phase    = 3'd0;
         r.cur.length   = 16'd0;
      end
      return r;
   endfunction

   function automatic cpt_state_type begin_seg(input cpt_state_type s, input logic [2:0] tone,
                                               input logic atten, input logic [2:0] nxt);
      cpt_state_type r;
      r = s;
      r.cur.flags.mute  = 1'b0;
      r.cur.flags.tone  = tone;
      r.cur.flags.atten = atten;
      r.cur.start       = s.now;
      r.cur.phase       = nxt;
      return r;
   endfunction

   function automatic cpt_state_type pause_step(input cpt_state_type s, input logic [31:0] el,
                                                input logic [31:0] limit, input logic mute,
                                                input logic [2:0] nxt);
      cpt_state_type r;
      r = s;
      if (el > limit) begin
         r.cur.flags.mute = mute;
         r.cur.start      = s.now;
         r.cur.phase      = nxt;
      end
      return r;
   endfunction

   function automatic cpt_state_type process(input cpt_state_type s);
      cpt_state_type r;
      logic [31:0]   el;
      logic [3:0]    k;
      logic [2:0]    ph;
      logic [2:0]    tone;
      r    = s;
      el   = s.now - s.cur.start;
      k    = s.cur_kind;
      ph   = s.cur.phase;
      tone = TONE_WAVE;
      if (k == KIND_OFF || k > KIND_WAVE3) begin
         r = s;
      end else if (k <= KIND_STATION || k >= KIND_WAVE1) begin
         if (ph == 3'd0) begin
            case (k)
               KIND_T600:    tone = TONE_600;
               KIND_T1000:   tone = TONE_1000;
               KIND_T2100:   tone = TONE_2100;
               KIND_STATION: tone = TONE_425;
               default:      tone = TONE_WAVE;
            endcase
            r = begin_seg(s, tone, k == KIND_STATION, 3'd1);
         end else if (ph == 3'd1 && el > {16'd0, s.cur.length}) begin
            r = end_signal(s);
         end
      end else if (ph == 3'd0) begin
         r = begin_seg(s, TONE_425, 1'b1, 3'd1);
      end else begin
         case (k)
            KIND_CALL: begin
               if (ph <= 3'd5) r = pause_step(s, el, CALL_BEEP_MS, ph[0], ph + 3'd1);
               else if (ph == 3'd6) r = pause_step(s, el, CALL_PAUSE_MS, 1'b0, 3'd0);
            end
            KIND_SENDCTRL: begin
               if (ph == 3'd1) r = pause_step(s, el, SEND_ON_MS, 1'b1, 3'd2);
               else if (ph == 3'd2) r = pause_step(s, el, SEND_OFF_MS, 1'b0, 3'd0);
            end
            KIND_BUSY: begin
               if (ph == 3'd1) begin
                  r = pause_step(s, el, BUSY_SEG_MS, 1'b1, 3'd2);
               end else if (ph == 3'd2 && el > BUSY_SEG_MS) begin
                  if (s.cur.length < BUSY_BURST_MS) begin
                     r = end_signal(s);
                  end else begin
                     // Next burst: one on/off pair less of the length budget.
                     r.cur.length     = s.cur.length - BUSY_BURST_MS;
                     r.cur.flags.mute = 1'b0;
                     r.cur.start      = s.now;
                     r.cur.phase      = 3'd1;
                  end
               end
            end
            KIND_UNAVAIL: begin
               if (el > UNAVAIL_STEP_MS) begin
                  if (ph == 3'd1) r = begin_seg(s, TONE_1000, 1'b1, 3'd2);
                  else if (ph == 3'd2) r = begin_seg(s, TONE_1200, 1'b1, 3'd3);
                  else if (ph == 3'd3) r = end_signal(s);
               end
            end
            KIND_OPVACK: begin
               if (ph == 3'd1) r = pause_step(s, el, OPV_ON_MS, 1'b1, 3'd2);
               else if (ph == 3'd2) r = pause_step(s, el, OPV_OFF_MS, 1'b0, 3'd0);
            end
            default: r = s;
         endcase
      end
      return r;
   endfunction

   cpt_state_type pre_state;
   logic          do_process;
   logic          act;

   always_comb begin
      pre_state  = state;
      do_process = 1'b0;
      case (req.req_type)
         REQ_TICK: begin
            pre_state.now = state.now + 32'd1;
            do_process    = 1'b1;
         end
         REQ_PLAY: begin
            if (req.signal_kind == KIND_OFF || req.signal_kind > KIND_WAVE3) begin
               pre_state = end_signal(state);
            end else begin
               // The running signal is saved even when it is off.
               pre_state.saved_kind = state.cur_kind;
               pre_state.saved      = state.cur;
               pre_state.cur_kind   = req.signal_kind;
               pre_state.cur.phase  = 3'd0;
               pre_state.cur.length = req.length_ms;
               do_process           = 1'b1;
            end
         end
         REQ_STOP: begin
            pre_state.saved_kind = KIND_OFF;
            pre_state.cur_kind   = KIND_OFF;
         end
         default: pre_state = state;
      endcase
      next_state = do_process ? process(pre_state) : pre_state;
   end

   always_comb begin
      act              = next_state.cur_kind != KIND_OFF;
      rsp.active       = act;
      rsp.current_kind = next_state.cur_kind;
      rsp.muted        = act & next_state.cur.flags.mute;
      rsp.tone_select  = act ? next_state.cur.flags.tone : TONE_NONE;
      rsp.attenuated   = act & next_state.cur.flags.atten;
   end

endmodule

@@ design/cpt_checker.sv @@
// Port-level checks for the call progress tone cadencer, bound to the top level.
module cpt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input cpt_pkg::cpt_rsp_type rsp_data
);
   import cpt_pkg::*;

   // No result word may be shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // Inactive words report no tone information at all.
   a_inactive_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.active |->
         !rsp_data.muted && rsp_data.tone_select == TONE_NONE && !rsp_data.attenuated
         && rsp_data.current_kind == KIND_OFF)
      else $error("inactive word carries tone fields");

   a_active_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.active |->
         rsp_data.current_kind != KIND_OFF && rsp_data.current_kind <= KIND_WAVE3
         && rsp_data.tone_select != 3'd7)
      else $error("active word with bad kind or tone");

   // With the result side empty, a word shows up only if a request was taken and passed through the input register.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid && req_ready) |=> !rsp_valid)
      else $error("result appeared without a request");

endmodule

bind call_progress_tone_cadencer cpt_checker u_cpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/call_progress_tone_cadencer_tb.sv @@
// Self-checking testbench for the call progress tone cadencer: directed table, then random cadences.
`timescale 1ns / 100ps

module call_progress_tone_cadencer_tb;
   import cpt_pkg::*;

   localparam logic [1:0] REQ_NONE    = 2'd3;
   localparam logic [3:0] KIND_WAVE2  = 4'd11;
   localparam logic [3:0] KIND_BAD_LO = 4'd13;
   localparam logic [3:0] KIND_BAD_HI = 4'd15;

   localparam cpt_rsp_type STATUS_OFF = '0;

   localparam int RAND_WORDS  = 1800;
   localparam int HOLD_AFTER  = 500;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 10;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   cpt_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   cpt_rsp_type rsp_data;

   call_progress_tone_cadencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   typedef struct {
      cpt_req_type word;
      bit          typed;
      cpt_rsp_type status;
   } dir_row_type;

   dir_row_type dir_rows[$];
   cpt_rsp_type status_due[$];

   int n_cycles  = 0;
   int n_sent    = 0;
   int n_checked = 0;
   int n_bad     = 0;

   // Predicted signal state.
   logic [31:0] ms_now    = '0;
   logic [3:0]  live_kind = KIND_OFF;
   logic [3:0]  held_kind = KIND_OFF;
   cpt_sig_type live      = '0;
   cpt_sig_type held      = '0;

   function automatic logic [31:0] seg_elapsed();
      return ms_now - live.start;
   endfunction

   function automatic void end_or_restore();
      if (held_kind != KIND_OFF) begin
         live_kind = held_kind;
         live      = held;
         held_kind = KIND_OFF;
      end else begin
         live_kind   = KIND_OFF;
         live.phase  = 3'd0;
         live.length = 16'd0;
      end
   endfunction

   function automatic void open_segment(logic mute, logic [2:0] tone, logic att,
                                        logic [2:0] nxt);
      live.flags.mute  = mute;
      live.flags.tone  = tone;
      live.flags.atten = att;
      live.start       = ms_now;
      live.phase       = nxt;
   endfunction

   function automatic void pause_after(logic [31:0] limit, logic mute, logic [2:0] nxt);
      if (seg_elapsed() > limit) begin
         live.flags.mute = mute;
         live.start      = ms_now;
         live.phase      = nxt;
      end
   endfunction

   function automatic void run_cadence();
      logic [2:0] tone;
      logic       att;
      if (live_kind == KIND_OFF || live_kind > KIND_WAVE3)
         return;
      // Plain tones and wave sources: one segment bounded by the length.
      if (live_kind <= KIND_STATION || live_kind >= KIND_WAVE1) begin
         if (live.phase == 3'd0) begin
            tone = TONE_WAVE;
            att  = 1'b0;
            case (live_kind)
               KIND_T600:  tone = TONE_600;
               KIND_T1000: tone = TONE_1000;
               KIND_T2100: tone = TONE_2100;
               KIND_STATION: begin
                  tone = TONE_425;
                  att  = 1'b1;
               end
               default: ;
            endcase
            open_segment(1'b0, tone, att, 3'd1);
         end else if (live.phase == 3'd1 && seg_elapsed() > {16'd0, live.length}) begin
            end_or_restore();
         end
         return;
      end
      if (live.phase == 3'd0) begin
         open_segment(1'b0, TONE_425, 1'b1, 3'd1);
         return;
      end
      case (live_kind)
         KIND_CALL: begin
            if (live.phase <= 3'd5)
               pause_after(CALL_BEEP_MS, live.phase[0], live.phase + 3'd1);
            else if (live.phase == 3'd6)
               pause_after(CALL_PAUSE_MS, 1'b0, 3'd0);
         end
         KIND_SENDCTRL: begin
            if (live.phase == 3'd1)
               pause_after(SEND_ON_MS, 1'b1, 3'd2);
            else if (live.phase == 3'd2)
               pause_after(SEND_OFF_MS, 1'b0, 3'd0);
         end
         KIND_BUSY: begin
            if (live.phase == 3'd1) begin
               pause_after(BUSY_SEG_MS, 1'b1, 3'd2);
            end else if (live.phase == 3'd2 && seg_elapsed() > BUSY_SEG_MS) begin
               // Each finished burst costs 600 ms of the remaining length.
               if (live.length < BUSY_BURST_MS) begin
                  end_or_restore();
               end else begin
                  live.length     = live.length - BUSY_BURST_MS;
                  live.flags.mute = 1'b0;
                  live.start      = ms_now;
                  live.phase      = 3'd1;
               end
            end
         end
         KIND_UNAVAIL: begin
            if (seg_elapsed() > UNAVAIL_STEP_MS) begin
               if (live.phase == 3'd1)
                  open_segment(1'b0, TONE_1000, 1'b1, 3'd2);
               else if (live.phase == 3'd2)
                  open_segment(1'b0, TONE_1200, 1'b1, 3'd3);
               else if (live.phase == 3'd3)
                  end_or_restore();
            end
         end
         KIND_OPVACK: begin
            if (live.phase == 3'd1)
               pause_after(OPV_ON_MS, 1'b1, 3'd2);
            else if (live.phase == 3'd2)
               pause_after(OPV_OFF_MS, 1'b0, 3'd0);
         end
         default: ;
      endcase
   endfunction

   function automatic cpt_rsp_type cadence_step(cpt_req_type w);
      cpt_rsp_type st;
      case (w.req_type)
         REQ_TICK: begin
            ms_now = ms_now + 32'd1;
            run_cadence();
         end
         REQ_PLAY: begin
            if (w.signal_kind == KIND_OFF || w.signal_kind > KIND_WAVE3) begin
               end_or_restore();
            end else begin
               // The running signal is saved even when it is off.
               held_kind   = live_kind;
               held        = live;
               live_kind   = w.signal_kind;
               live.phase  = 3'd0;
               live.length = w.length_ms;
               run_cadence();
            end
         end
         REQ_STOP: begin
            held_kind = KIND_OFF;
            live_kind = KIND_OFF;
         end
         default: ;
      endcase
      st.active       = (live_kind != KIND_OFF);
      st.current_kind = live_kind;
      st.muted        = st.active & live.flags.mute;
      st.tone_select  = st.active ? live.flags.tone : TONE_NONE;
      st.attenuated   = st.active & live.flags.atten;
      return st;
   endfunction

   function automatic cpt_req_type make_word(logic [1:0] rt, logic [3:0] kind,
                                             logic [15:0] len);
      cpt_req_type w;
      w.req_type    = rt;
      w.signal_kind = kind;
      w.length_ms   = len;
      return w;
   endfunction

   function automatic cpt_rsp_type make_status(logic act, logic [3:0] kind, logic mute,
                                               logic [2:0] tone, logic att);
      cpt_rsp_type st;
      st.active       = act;
      st.current_kind = kind;
      st.muted        = mute;
      st.tone_select  = tone;
      st.attenuated   = att;
      return st;
   endfunction

   function automatic void add_row(logic [1:0] rt, logic [3:0] kind, logic [15:0] len,
                                   bit typed, cpt_rsp_type st);
      dir_row_type row;
      row.word   = make_word(rt, kind, len);
      row.typed  = typed;
      row.status = st;
      dir_rows.push_back(row);
   endfunction

   // Idle cycles before a word; some stretches of the run go without any idling.
   function automatic int idle_cycles();
      if (n_cycles % 3000 < 600)
         return 0;
      return $urandom_range(0, 9);
   endfunction

   function automatic logic [15:0] play_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 16'($urandom_range(0, 700));
      if (r < 85)
         return 16'($urandom_range(700, 6000));
      return 16'($urandom());
   endfunction

   function automatic void report_bad(string what, cpt_rsp_type want, cpt_rsp_type got);
      n_bad++;
      if (n_bad <= MAX_REPORTS)
         $display("status word %0d %s: expected act=%0b kind=%0d mute=%0b tone=%0d att=%0b,",
                  n_checked, what, want.active, want.current_kind, want.muted,
                  want.tone_select, want.attenuated,
                  " got act=%0b kind=%0d mute=%0b tone=%0d att=%0b",
                  got.active, got.current_kind, got.muted, got.tone_select, got.attenuated);
   endfunction

   task automatic send_word(input cpt_req_type w, input bit typed, input cpt_rsp_type st);
      int          gap;
      cpt_rsp_type due;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due = cadence_step(w);
      status_due.push_back(typed ? st : due);
      n_sent++;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin : run_limit
      while (n_cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         n_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: draws its own idle time per word and once holds off for a long stretch.
   initial begin : status_sink
      cpt_rsp_type want;
      int          rx_wait;
      rx_wait   = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_ready <= (rx_wait == 0);
         if (rx_wait > 0)
            rx_wait--;
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (status_due.size() == 0) begin
               report_bad("unexpected", STATUS_OFF, rsp_data);
            end else begin
               want = status_due.pop_front();
               if (rsp_data !== want)
                  report_bad("mismatch", want, rsp_data);
            end
            rx_wait = idle_cycles();
            if (n_checked == HOLD_AFTER)
               rx_wait = HOLD_CYCLES;
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int         run;
      int         pick;
      int         k;
      logic [3:0] kind;
      req_valid = 1'b0;
      req_data  = '0;

      add_row(REQ_TICK, KIND_OFF, 16'd0, 1'b1, STATUS_OFF);
      add_row(REQ_NONE, KIND_BAD_HI, 16'hFFFF, 1'b1, STATUS_OFF);
      add_row(REQ_STOP, KIND_OFF, 16'd0, 1'b1, STATUS_OFF);
      add_row(REQ_PLAY, KIND_T600, 16'd0, 1'b1,
              make_status(1'b1, KIND_T600, 1'b0, TONE_600, 1'b0));
      add_row(REQ_TICK, KIND_OFF, 16'd0, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_STATION, 16'hFFFF, 1'b1,
              make_status(1'b1, KIND_STATION, 1'b0, TONE_425, 1'b1));
      add_row(REQ_PLAY, KIND_WAVE3, 16'hFFFF, 1'b1,
              make_status(1'b1, KIND_WAVE3, 1'b0, TONE_WAVE, 1'b0));
      // Play off brings back the saved station tone.
      add_row(REQ_PLAY, KIND_OFF, 16'd0, 1'b1,
              make_status(1'b1, KIND_STATION, 1'b0, TONE_425, 1'b1));
      // An unknown kind acts as play off, and nothing is saved any more.
      add_row(REQ_PLAY, KIND_BAD_HI, 16'hFFFF, 1'b1, STATUS_OFF);
      add_row(REQ_PLAY, KIND_T2100, 16'hFFFF, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_CALL, 16'd0, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_T1000, 16'd1, 1'b0, STATUS_OFF);
      add_row(REQ_TICK, KIND_OFF, 16'd0, 1'b0, STATUS_OFF);
      add_row(REQ_TICK, KIND_OFF, 16'd0, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_BUSY, 16'd0, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_UNAVAIL, 16'hFFFF, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_OPVACK, 16'd200, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_SENDCTRL, 16'h8000, 1'b0, STATUS_OFF);
      add_row(REQ_STOP, KIND_OFF, 16'd0, 1'b1, STATUS_OFF);
      add_row(REQ_PLAY, KIND_WAVE2, 16'd0, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_BAD_LO, 16'h5555, 1'b0, STATUS_OFF);
      add_row(REQ_PLAY, KIND_WAVE1, 16'd1, 1'b0, STATUS_OFF);
      add_row(REQ_TICK, KIND_OFF, 16'd0, 1'b0, STATUS_OFF);
      add_row(REQ_NONE, KIND_BAD_HI, 16'hFFFF, 1'b0, STATUS_OFF);
      add_row(REQ_STOP, KIND_BAD_HI, 16'hFFFF, 1'b0, STATUS_OFF);

      @(negedge clock);
      while (reset) @(negedge clock);

      foreach (dir_rows[i])
         send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].status);

      // Each sequence: some noise, a play command, then a run of ticks with
      // the odd nested play, play off, stop or unknown word mixed in.
      while (n_sent < dir_rows.size() + RAND_WORDS) begin
         if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3))
               send_word(make_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                   16'($urandom())), 1'b0, STATUS_OFF);
         send_word(make_word(REQ_PLAY, 4'($urandom_range(1, 12)), play_length()),
                   1'b0, STATUS_OFF);
         pick = $urandom_range(0, 99);
         if (pick < 65)
            run = $urandom_range(1, 30);
         else if (pick < 92)
            run = $urandom_range(30, 650);
         else
            run = $urandom_range(650, 5400);
         // The last sequence is cut short so the word count stays near its target.
         if (run > dir_rows.size() + RAND_WORDS - n_sent)
            run = dir_rows.size() + RAND_WORDS - n_sent;
         repeat (run) begin
            pick = $urandom_range(0, 999);
            if (pick < 15) begin
               // Short-lived tone that ends on its own and restores the cadence.
               k    = $urandom_range(0, 6);
               kind = 4'((k < 4) ? k + 1 : k + 6);
               send_word(make_word(REQ_PLAY, kind, 16'($urandom_range(0, 120))),
                         1'b0, STATUS_OFF);
            end else if (pick < 22) begin
               send_word(make_word(REQ_PLAY, 4'($urandom_range(0, 15)), play_length()),
                         1'b0, STATUS_OFF);
            end else if (pick < 27) begin
               send_word(make_word(REQ_PLAY, KIND_OFF, 16'($urandom())), 1'b0, STATUS_OFF);
            end else if (pick < 30) begin
               send_word(make_word(REQ_STOP, 4'($urandom_range(0, 15)), 16'($urandom())),
                         1'b0, STATUS_OFF);
            end else if (pick < 33) begin
               send_word(make_word(REQ_NONE, 4'($urandom_range(0, 15)), 16'($urandom())),
                         1'b0, STATUS_OFF);
            end else begin
               send_word(make_word(REQ_TICK, 4'($urandom_range(0, 15)), 16'($urandom())),
                         1'b0, STATUS_OFF);
            end
         end
      end

      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (n_bad == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
design/cpt_pkg.sv
design/cpt_engine.sv
design/call_progress_tone_cadencer.sv
design/cpt_checker.sv
tb/call_progress_tone_cadencer_tb.sv
